@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg
// Shared types and constants of the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;
  localparam int Depth = 128;
  localparam int WordBits = 32;
  localparam int IdxBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  typedef logic signed [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_READ   = 3'd3,
    OP_SORT   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         found_index;
    logic [7:0]         entry_count;
    logic               list_empty;
    logic               list_full;
  } out_item_t;

  // Command that every cell sees in the same cycle.
  typedef struct packed {
    logic              ins;   // shift up at and above pos, write val at pos
    logic              rem;   // shift down above pos
    logic              sort_even; // odd-even transposition, even pairs
    logic              sort_odd;
    logic [IdxBits:0]  pos;
    logic [IdxBits:0]  count;
    word_t             val;
  } cell_cmd_t;
endpackage

@@ hw/rtl/oale_cell.sv @@
// ----------------------------------------------------------------------------
// oale_cell
// One list slot: holds one word and trades it with its neighbors.
// ----------------------------------------------------------------------------
module oale_cell (
  input  logic               clk_i,
  input  logic [oale_pkg::IdxBits-1:0] idx_i,
  input  oale_pkg::cell_cmd_t cmd_i,
  input  oale_pkg::word_t    lower_i,
  input  oale_pkg::word_t    upper_i,
  output oale_pkg::word_t    word_o
);
  import oale_pkg::*;

  word_t word_q;
  word_t word_d;
  logic [IdxBits:0] idx;
  logic lower_pair;
  logic upper_pair;

  assign idx = {1'b0, idx_i};

  always_comb begin
    word_d = word_q;
    // In a transposition pass, a cell is the low or high half of a pair.
    lower_pair = (idx_i[0] == cmd_i.sort_odd) && (idx + 1'b1 < cmd_i.count);
    upper_pair = (idx_i[0] != cmd_i.sort_odd) && (idx != '0) && (idx < cmd_i.count);
    if (cmd_i.ins) begin
      if (idx == cmd_i.pos) begin
        word_d = cmd_i.val;
      end else if (idx > cmd_i.pos) begin
        word_d = lower_i;
      end
    end else if (cmd_i.rem) begin
      if (idx >= cmd_i.pos) begin
        word_d = upper_i;
      end
    end else if (cmd_i.sort_even || cmd_i.sort_odd) begin
      if (lower_pair && (upper_i < word_q)) begin
        word_d = upper_i;
      end else if (upper_pair && (word_q < lower_i)) begin
        word_d = lower_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
endmodule

@@ hw/rtl/oale_chain.sv @@
// ----------------------------------------------------------------------------
// oale_chain
// Row of list cells, each wired to its neighbors; an end cell sees its own word.
// ----------------------------------------------------------------------------
module oale_chain (
  input  logic                clk_i,
  input  oale_pkg::cell_cmd_t cmd_i,
  output oale_pkg::word_t     words_o [oale_pkg::Depth]
);
  import oale_pkg::*;

  word_t words [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    word_t lower;
    word_t upper;
    if (g == 0) begin : g_lo
      assign lower = words[0];
    end else begin : g_lo_n
      assign lower = words[g-1];
    end
    if (g == Depth - 1) begin : g_hi
      assign upper = words[g];
    end else begin : g_hi_n
      assign upper = words[g+1];
    end
    oale_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxBits'(g)),
      .cmd_i  (cmd_i),
      .lower_i(lower),
      .upper_i(upper),
      .word_o (words[g])
    );
  end

  assign words_o = words;
endmodule

@@ hw/rtl/ordered_array_list_engine_top.sv @@
// Insert and remove shift all cells at once.
// Read and search walk the chain one cell a cycle, from index zero upward.
// Sort runs count odd-even transposition passes over the chain.
// One item is in flight at a time; the next beat is taken once the result leaves.
// Reset (rst_ni low, asynchronous) empties the list and sets the limit to 128.
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Bounded signed-word list with insert, remove, search, read and sort.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  oale_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output oale_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);
  import oale_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [7:0]       limit_q;
  logic [IdxBits:0] count_q, count_d;
  logic [IdxBits:0] step_q, step_d;
  logic             odd_q, odd_d;
  in_item_t         item_q;
  out_item_t        res_q, res_d;
  cell_cmd_t        cmd;
  word_t            words [Depth];
  logic             accept;
  logic [IdxBits:0] lim;
  logic [IdxBits:0] pos;
  logic             full;
  logic [IdxBits:0] cnt_res;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign lim = (limit_q > 8'(Depth)) ? (IdxBits+1)'(Depth) : limit_q[IdxBits:0];
  assign pos = {1'b0, in_data_i.position[IdxBits-1:0]};
  assign full = count_q >= lim;

  oale_chain u_chain (.clk_i(clk_i), .cmd_i(cmd), .words_o(words));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    step_d = step_q;
    odd_d = odd_q;
    res_d = res_q;
    cmd = '0;
    cmd.count = count_q;
    cmd.val = in_data_i.value;
    cmd.pos = pos;
    cnt_res = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          res_d.status = ST_OK;
          state_d = S_DONE;
          unique case (in_data_i.operation)
            OP_INSERT: begin
              if (in_data_i.position > 8'(count_q)) begin
                res_d.status = ST_RANGE;
              end else if (full) begin
                res_d.status = ST_FULL;
              end else begin
                cmd.ins = 1'b1;
                cnt_res = count_q + 1'b1;
                count_d = cnt_res;
              end
            end
            OP_REMOVE: begin
              if (in_data_i.position >= 8'(count_q)) begin
                res_d.status = ST_RANGE;
              end else begin
                cmd.rem = 1'b1;
                cnt_res = count_q - 1'b1;
                count_d = cnt_res;
              end
            end
            OP_SEARCH: begin
              step_d = '0;
              state_d = S_WALK;
            end
            OP_READ: begin
              if (in_data_i.position >= 8'(count_q)) begin
                res_d.status = ST_RANGE;
              end else begin
                step_d = '0;
                state_d = S_WALK;
              end
            end
            OP_SORT: begin
              step_d = '0;
              odd_d = 1'b0;
              state_d = S_SORT;
            end
            default: ;
          endcase
          res_d.entry_count = 8'(cnt_res);
          res_d.list_empty = (cnt_res == '0);
          res_d.list_full = (cnt_res >= lim);
        end
      end
      S_WALK: begin
        // Step through the cells, one per cycle, from index zero upward.
        if (item_q.operation == OP_READ) begin
          if (step_q == {1'b0, item_q.position[IdxBits-1:0]}) begin
            res_d.read_value = words[step_q[IdxBits-1:0]];
            state_d = S_DONE;
          end
        end else if (step_q >= count_q) begin
          res_d.status = ST_NOTFOUND;
          state_d = S_DONE;
        end else if (words[step_q[IdxBits-1:0]] == item_q.value) begin
          res_d.found_index = 7'(step_q);
          state_d = S_DONE;
        end
        step_d = step_q + 1'b1;
      end
      S_SORT: begin
        if (step_q >= count_q) begin
          state_d = S_DONE;
        end else begin
          cmd.sort_even = !odd_q;
          cmd.sort_odd = odd_q;
          odd_d = !odd_q;
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      limit_q <= 8'd128;
      step_q <= '0;
      odd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q <= step_d;
      odd_q <= odd_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // The full flag follows the limit in force when the result leaves.
  always_comb begin
    out_data_o = res_q;
    out_data_o.list_full = (count_q >= lim);
  end
  assign out_valid_o = (state_q == S_DONE);
endmodule

@@ hw/rtl/oale_checker.sv @@
// ----------------------------------------------------------------------------
// oale_checker
// Port-level checks of the ordered array list engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module oale_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input oale_pkg::out_item_t out_data_o
);
  import oale_pkg::*;

  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
    "engine took a beat while one is in flight")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    ##1 (out_valid_o && $stable(out_data_o)), "stalled result changed")
  `ASSERT_IMPL(a_empty_flag, clk_i, rst_ni, out_valid_o,
    out_data_o.list_empty == (out_data_o.entry_count == 8'd0), "empty flag wrong")
  `ASSERT_IMPL(a_out_busy, clk_i, rst_ni, out_valid_o, in_stall_o,
    "result shown while input open")
endmodule

bind ordered_array_list_engine_top oale_checker u_oale_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered array list engine: a local list model
// predicts each result, beats are driven in random bursts, results are
// compared field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
  import oale_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  ordered_array_list_engine_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the list.
  logic signed [31:0] list_words [Depth];
  int unsigned        list_len;
  int unsigned        cap_reg;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors = 0;
  int        n_results = 0;
  bit        sender_pause = 1'b0;
  int        hold_cycles = 0;
  int        gap_left = 0;
  int        burst_left = 0;

  function automatic int unsigned eff_limit();
    return (cap_reg > Depth) ? Depth : cap_reg;
  endfunction

  function automatic out_item_t apply_operation(in_item_t it);
    out_item_t r;
    logic signed [31:0] t;
    int unsigned p;
    int j;
    r = '0;
    p = it.position;
    r.status = ST_OK;
    case (it.operation)
      OP_INSERT: begin
        if (p > list_len) r.status = ST_RANGE;
        else if (list_len >= eff_limit()) r.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = it.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (list_len == 0 || p >= list_len) r.status = ST_RANGE;
        else begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == it.value) begin
            r.status = ST_OK;
            r.found_index = i[6:0];
            break;
          end
      end
      OP_READ: begin
        if (list_len == 0 || p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_words[p];
      end
      OP_SORT: begin
        for (int i = 1; i < list_len; i++) begin
          j = i;
          while (j > 0 && list_words[j] < list_words[j-1]) begin
            t = list_words[j-1];
            list_words[j-1] = list_words[j];
            list_words[j] = t;
            j--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = list_len[7:0];
    r.list_empty = (list_len == 0);
    r.list_full = (list_len >= eff_limit());
    return r;
  endfunction

  // Driver: bursts of beats with random gaps; a stalled beat is held.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_operation(in_data_i));
        void'(pending_items.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // keep the stalled beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0 && !sender_pause) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data_o.status); errors++;
          end
          if (out_data_o.read_value !== e.read_value) begin
            $error("read_value exp %0d got %0d", e.read_value, out_data_o.read_value);
            errors++;
          end
          if (out_data_o.found_index !== e.found_index) begin
            $error("found_index exp %0d got %0d", e.found_index, out_data_o.found_index);
            errors++;
          end
          if (out_data_o.entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, out_data_o.entry_count);
            errors++;
          end
          if (out_data_o.list_empty !== e.list_empty) begin
            $error("list_empty exp %0b got %0b", e.list_empty, out_data_o.list_empty);
            errors++;
          end
          if (out_data_o.list_full !== e.list_full) begin
            $error("list_full exp %0b got %0b", e.list_full, out_data_o.list_full);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  function automatic in_item_t make_item(op_e op, logic signed [31:0] v, int unsigned p);
    in_item_t it;
    it.operation = op;
    it.value = v;
    it.position = p[7:0];
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  // Mostly small values so searches hit; sometimes any word.
  function automatic logic signed [31:0] rand_word();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $signed($urandom_range(0, 15)) - 8;
  endfunction

  task automatic random_phase(int n);
    int unsigned len;
    int unsigned op;
    len = list_len;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(0, 19);
      if (op < 8)       pending_items.push_back(make_item(OP_INSERT, rand_word(),
                          $urandom_range(0, 6) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(0, len)));
      else if (op < 11) pending_items.push_back(make_item(OP_REMOVE, rand_word(),
                          $urandom_range(0, 6) == 0 ? $urandom_range(0, 255)
                          : (len == 0 ? 0 : $urandom_range(0, len - 1))));
      else if (op < 14) pending_items.push_back(make_item(OP_SEARCH, rand_word(), 0));
      else if (op < 17) pending_items.push_back(make_item(OP_READ, $urandom(),
                          $urandom_range(0, 5) == 0 ? $urandom_range(0, 255)
                          : (len == 0 ? 0 : $urandom_range(0, len - 1))));
      else if (op < 19) pending_items.push_back(make_item(OP_SORT, $urandom(),
                          $urandom_range(0, 255)));
      else begin
        in_item_t it;
        it.operation = 3'($urandom_range(5, 7));
        it.value = $urandom();
        it.position = 8'($urandom());
        pending_items.push_back(it);
      end
      // Rough length estimate only steers positions.
      if (op < 8 && len < 128) len++;
      else if (op < 11 && len > 0) len--;
    end
  endtask

  initial begin
    list_len = 0;
    cap_reg = 128;
    for (int i = 0; i < Depth; i++) list_words[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases, extremes, every operation.
    pending_items.push_back(make_item(OP_REMOVE, 0, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0));
    pending_items.push_back(make_item(OP_SEARCH, 0, 0));
    pending_items.push_back(make_item(OP_SORT, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 32'sh7fffffff, 1));
    pending_items.push_back(make_item(OP_INSERT, 32'sh7fffffff, 0));
    pending_items.push_back(make_item(OP_INSERT, 32'sh80000000, 0));
    pending_items.push_back(make_item(OP_INSERT, -1, 2));
    pending_items.push_back(make_item(OP_INSERT, 5, 1));
    pending_items.push_back(make_item(OP_INSERT, 5, 4));
    pending_items.push_back(make_item(OP_SEARCH, 5, 0));
    pending_items.push_back(make_item(OP_SEARCH, 1234, 0));
    pending_items.push_back(make_item(OP_READ, 0, 4));
    pending_items.push_back(make_item(OP_READ, 0, 5));
    pending_items.push_back(make_item(OP_READ, 0, 255));
    pending_items.push_back(make_item(OP_SORT, 0, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0));
    pending_items.push_back(make_item(OP_REMOVE, 0, 4));
    pending_items.push_back(make_item(OP_REMOVE, 0, 5));
    pending_items.push_back(make_item(OP_REMOVE, 0, 0));
    pending_items.push_back(make_item(op_e'(3'd7), 32'shffffffff, 8'hff));
    pending_items.push_back(make_item(op_e'(3'd5), 0, 0));
    wait_drained();

    // Tiny limit, then lowered below count.
    write_limit(3);
    random_phase(40);
    wait_drained();
    write_limit(0);
    random_phase(30);
    wait_drained();
    write_limit(255);
    // Fill the list with the receiver held off so the input backs up.
    for (int k = 0; k < 130; k++)
      pending_items.push_back(make_item(OP_INSERT, rand_word(), 0));
    hold_cycles = 400;
    wait_drained();
    pending_items.push_back(make_item(OP_INSERT, 1, 0));
    pending_items.push_back(make_item(OP_SORT, 0, 0));
    random_phase(60);
    wait_drained();
    write_limit(128);
    for (int k = 0; k < 120; k++)
      pending_items.push_back(make_item(OP_REMOVE, 0, 0));
    wait_drained();
    write_limit(20);
    random_phase(200);
    // Sender waits for every result before going on.
    sender_pause = 1'b1;
    while (expected_results.size() > 0 || in_valid_i) @(posedge clk_i);
    sender_pause = 1'b0;
    wait_drained();
    write_limit(128);
    random_phase(200);
    wait_drained();

    $display("Covered %0d results over limits 0, 3, 20, 128 and 255,", n_results);
    $display("with fill to full, drain to empty and back-pressure.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
